// File: src/pspt_pkg.sv
`timescale 1ns / 1ps
package pspt_pkg;

  localparam int unsigned ServiceSlotsDefault = 64;
  localparam int unsigned PidSlotsDefault     = 64;

  localparam logic [12:0] PidLowLimit   = 13'h0010;
  localparam logic [12:0] PidNullValue  = 13'h1fff;
  localparam logic [12:0] PidStoreLimit = 13'h0012;
  localparam logic [11:0] HeaderBytes   = 12'd9;
  localparam logic [8:0]  EntryCountMax = 9'd511;

  localparam int unsigned InDataW  = 8;
  localparam int unsigned OutDataW = 48;
  localparam int unsigned OutUserW = 4;
  localparam int unsigned QueueDepth = 4;

  // parsed entry handed from the front to the back
  typedef struct packed {
    logic [15:0] service_number;
    logic [12:0] map_pid;
    logic [15:0] stream_id;
    logic        entry_invalid;
  } pspt_entry_t;

  // result flags, highest bit first, same bit order as tuser
  typedef struct packed {
    logic store_full;
    logic entry_invalid;
    logic map_pid_added;
    logic service_added;
  } pspt_flags_t;

endpackage

// File: src/pspt_front.sv
`timescale 1ns / 1ps
module pspt_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [7:0]           byte_i,
  input  logic                 start_i,
  input  logic                 accept_i,
  output logic                 entry_valid_o,
  output pspt_pkg::pspt_entry_t entry_o
);
  import pspt_pkg::*;

  logic [3:0]  pos_q, pos_d;
  logic [11:0] len_q, len_d;
  logic [15:0] tsid_q, tsid_d;
  logic [8:0]  remain_q, remain_d;
  logic [23:0] shift_q, shift_d;
  logic        ignored_q, ignored_d;
  logic [11:0] len_full;
  logic [11:0] len_sub;
  logic [12:0] pid_w;
  logic        pid_bad;

  assign len_full = {len_q[11:8], byte_i};
  assign len_sub  = len_full - HeaderBytes;
  assign pid_w    = {shift_q[4:0], byte_i};
  assign pid_bad  = (pid_w < PidLowLimit) || (pid_w >= PidNullValue);

  // header and entry byte walk
  always_comb begin
    pos_d = pos_q;
    len_d = len_q;
    tsid_d = tsid_q;
    remain_d = remain_q;
    shift_d = shift_q;
    ignored_d = ignored_q;
    entry_valid_o = 1'b0;
    entry_o.service_number = shift_q[23:8];
    entry_o.map_pid = pid_w;
    entry_o.stream_id = tsid_q;
    entry_o.entry_invalid = pid_bad;
    if (accept_i) begin
      if (start_i) begin
        ignored_d = (byte_i != 8'd0);
        pos_d = 4'd1;
        remain_d = '0;
        shift_d = '0;
      end else if (!ignored_q) begin
        unique case (pos_q)
          4'd1: begin
            len_d = {byte_i[3:0], 8'd0};
            pos_d = 4'd2;
          end
          4'd2: begin
            len_d = len_full;
            // (len-9)/4 fits 10 bits; saturates to 511
            if (len_full < HeaderBytes) remain_d = '0;
            else if (len_sub[11:2] > {1'b0, EntryCountMax}) remain_d = EntryCountMax;
            else remain_d = len_sub[10:2];
            pos_d = 4'd3;
          end
          4'd3: begin
            tsid_d = {byte_i, 8'd0};
            pos_d = 4'd4;
          end
          4'd4: begin
            tsid_d = {tsid_q[15:8], byte_i};
            pos_d = 4'd5;
          end
          4'd5, 4'd6, 4'd7: pos_d = pos_q + 4'd1;
          default: begin
            if (remain_q != '0) begin
              if (pos_q < 4'd11) begin
                shift_d = {shift_q[15:0], byte_i};
                pos_d = pos_q + 4'd1;
              end else begin
                pos_d = 4'd8;
                remain_d = remain_q - 9'd1;
                shift_d = '0;
                entry_valid_o = 1'b1;
                if (pid_bad) begin
                  ignored_d = 1'b1;
                  remain_d = '0;
                end
              end
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      len_q <= '0;
      tsid_q <= '0;
      remain_q <= '0;
      shift_q <= '0;
      ignored_q <= 1'b1;
    end else begin
      pos_q <= pos_d;
      len_q <= len_d;
      tsid_q <= tsid_d;
      remain_q <= remain_d;
      shift_q <= shift_d;
      ignored_q <= ignored_d;
    end
  end
endmodule

// File: src/pspt_queue.sv
`timescale 1ns / 1ps
module pspt_queue #(
  parameter int unsigned Depth = pspt_pkg::QueueDepth
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  pspt_pkg::pspt_entry_t data_i,
  output logic                  full_o,
  output logic                  empty_o,
  input  logic                  pop_i,
  output pspt_pkg::pspt_entry_t data_o
);
  import pspt_pkg::*;

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

  pspt_entry_t mem_q [Depth];
  logic [AW-1:0] wr_q, rd_q;
  logic [AW:0]   cnt_q;

  assign full_o  = (cnt_q == AW'(0) + (AW+1)'(Depth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= (wr_q == AW'(Depth - 1)) ? '0 : wr_q + AW'(1);
      if (pop_i)  rd_q <= (rd_q == AW'(Depth - 1)) ? '0 : rd_q + AW'(1);
      unique case ({push_i, pop_i})
        2'b10: cnt_q <= cnt_q + (AW+1)'(1);
        2'b01: cnt_q <= cnt_q - (AW+1)'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end
endmodule

// File: src/pspt_back.sv
`timescale 1ns / 1ps
module pspt_back #(
  parameter int unsigned ServiceSlots = pspt_pkg::ServiceSlotsDefault,
  parameter int unsigned PidSlots     = pspt_pkg::PidSlotsDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  empty_i,
  input  pspt_pkg::pspt_entry_t entry_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output pspt_pkg::pspt_entry_t out_entry_o,
  output pspt_pkg::pspt_flags_t out_flags_o
);
  import pspt_pkg::*;

  localparam int unsigned SW = (ServiceSlots > 1) ? $clog2(ServiceSlots) : 1;
  localparam int unsigned PW = (PidSlots > 1) ? $clog2(PidSlots) : 1;

  // tables in flops for the parallel compare
  logic [15:0] svc_key_q [ServiceSlots];
  logic [28:0] svc_rest_q [ServiceSlots];
  logic [ServiceSlots-1:0] svc_vld_q;
  logic [12:0] pid_key_q [PidSlots];
  logic [PidSlots-1:0] pid_vld_q;

  logic        svc_hit, pid_hit, svc_free, pid_free;
  logic [SW-1:0] svc_slot;
  logic [PW-1:0] pid_slot;
  logic        take, storable, svc_add, pid_add, rec;
  pspt_flags_t flags;

  // match and lowest free slot search
  always_comb begin
    svc_hit = 1'b0;
    svc_free = 1'b0;
    svc_slot = '0;
    for (int k = ServiceSlots - 1; k >= 0; k--) begin
      if (svc_vld_q[k] && svc_key_q[k] == entry_i.service_number) svc_hit = 1'b1;
      if (!svc_vld_q[k]) begin
        svc_free = 1'b1;
        svc_slot = SW'(k);
      end
    end
    pid_hit = 1'b0;
    pid_free = 1'b0;
    pid_slot = '0;
    for (int k = PidSlots - 1; k >= 0; k--) begin
      if (pid_vld_q[k] && pid_key_q[k] == entry_i.map_pid) pid_hit = 1'b1;
      if (!pid_vld_q[k]) begin
        pid_free = 1'b1;
        pid_slot = PW'(k);
      end
    end
  end

  assign take = !empty_i && (!out_valid_o || out_ready_i);
  assign pop_o = take;
  assign storable = !entry_i.entry_invalid && (entry_i.map_pid > PidStoreLimit)
                    && (entry_i.service_number != 16'd0);
  assign svc_add = storable && !svc_hit && svc_free;
  assign pid_add = storable && !pid_hit && pid_free;
  assign flags.service_added = svc_add;
  assign flags.map_pid_added = pid_add;
  assign flags.entry_invalid = entry_i.entry_invalid;
  assign flags.store_full = storable && ((!svc_hit && !svc_free) || (!pid_hit && !pid_free));
  assign rec = entry_i.entry_invalid || (storable && !(svc_hit && pid_hit));

  // table writes
  always_ff @(posedge clk_i) begin
    if (take && svc_add) begin
      svc_key_q[svc_slot] <= entry_i.service_number;
      svc_rest_q[svc_slot] <= {entry_i.stream_id, entry_i.map_pid};
    end
    if (take && pid_add) pid_key_q[pid_slot] <= entry_i.map_pid;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      svc_vld_q <= '0;
      pid_vld_q <= '0;
    end else begin
      if (take && svc_add) svc_vld_q[svc_slot] <= 1'b1;
      if (take && pid_add) pid_vld_q[pid_slot] <= 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (!out_valid_o || out_ready_i) begin
      out_valid_o <= take && rec;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_entry_o <= entry_i;
      out_flags_o <= flags;
    end
  end
endmodule

// File: src/pat_section_program_table_top.sv
`timescale 1ns / 1ps
// Program association section parser. Section bytes enter one per cycle while
// the queue is not full; the front walks the header and gathers four-byte
// entries, a four-deep queue holds parsed entries, and the back compares each
// against the service and map-PID tables combinationally and writes one record
// for each new, full or invalid entry. Throughput is one byte per cycle while
// the queue has room; an entry is registered in the queue, then in the output register.
module pat_section_program_table_top #(
  parameter int unsigned SERVICE_SLOTS = pspt_pkg::ServiceSlotsDefault,
  parameter int unsigned PID_SLOTS     = pspt_pkg::PidSlotsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [pspt_pkg::InDataW-1:0]  s_axis_tdata,  // section_byte
  input  logic                          s_axis_tuser,  // section_start
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // service_number, map_pid, stream_id, zero fill
  output logic [pspt_pkg::OutDataW-1:0] m_axis_tdata,
  // service_added, map_pid_added, entry_invalid, store_full
  output logic [pspt_pkg::OutUserW-1:0] m_axis_tuser
);
  import pspt_pkg::*;

  logic        acc, fe_valid, q_full, q_empty, pop;
  pspt_entry_t fe_entry, q_entry, out_entry;
  pspt_flags_t out_flags;

  assign s_axis_tready = !q_full;
  assign acc = s_axis_tvalid && s_axis_tready;

  pspt_front u_front (
    .clk_i, .rst_ni,
    .byte_i(s_axis_tdata), .start_i(s_axis_tuser), .accept_i(acc),
    .entry_valid_o(fe_valid), .entry_o(fe_entry)
  );

  pspt_queue u_queue (
    .clk_i, .rst_ni,
    .push_i(fe_valid), .data_i(fe_entry), .full_o(q_full), .empty_o(q_empty),
    .pop_i(pop), .data_o(q_entry)
  );

  pspt_back #(.ServiceSlots(SERVICE_SLOTS), .PidSlots(PID_SLOTS)) u_back (
    .clk_i, .rst_ni,
    .empty_i(q_empty), .entry_i(q_entry), .pop_o(pop),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .out_entry_o(out_entry), .out_flags_o(out_flags)
  );

  assign m_axis_tdata = {3'd0, out_entry.stream_id, out_entry.map_pid,
                         out_entry.service_number};
  assign m_axis_tuser = {out_flags.store_full, out_flags.entry_invalid,
                         out_flags.map_pid_added, out_flags.service_added};
endmodule

// File: src/pspt_checker.sv
`timescale 1ns / 1ps
module pspt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata,
  input logic [3:0]  m_axis_tuser
);
  // stalled record holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("record changed under stall");

  // invalid record carries no store flags
  a_inv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[2] |-> m_axis_tuser[0] == 1'b0
      && m_axis_tuser[1] == 1'b0 && m_axis_tuser[3] == 1'b0)
    else $error("invalid record with store flags");

  // each record reports something
  a_any: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tuser != 4'd0)
    else $error("empty record");

  // padding bits stay zero
  a_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[47:45] == 3'd0)
    else $error("padding nonzero");
endmodule

bind pat_section_program_table_top pspt_checker u_pspt_checker (
  .clk_i, .rst_ni,
  .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
);

// File: dv/tb_pat_section_program_table_top.sv
`timescale 1ns / 1ps
module tb_pat_section_program_table_top;
  import pspt_pkg::*;

  localparam int unsigned SvcSlots   = 64;
  localparam int unsigned PmtSlots   = 64;
  localparam int unsigned RandItems  = 700;
  localparam int unsigned CycleLimit = 600000;
  localparam int unsigned DrainWait  = 20;

  // one parsed-entry record as the block reports it
  typedef struct packed {
    logic [15:0] service_number;
    logic [12:0] map_pid;
    logic [15:0] stream_id;
    pspt_flags_t flags;
  } pat_record_t;

  // one directed row; typed rows carry their record
  typedef struct packed {
    logic [7:0]  sbyte;
    logic        sstart;
    logic        typed;
    pat_record_t rec;
  } dir_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic                s_axis_tuser = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic [OutUserW-1:0] m_axis_tuser;

  pat_record_t record_q[$];
  int unsigned err_count = 0;
  int unsigned cycle_count = 0;

  // parser model state
  logic [9:0]  pm_pos;
  logic [11:0] pm_len;
  logic [15:0] pm_tsid;
  logic [8:0]  pm_left;
  logic [23:0] pm_shift;
  logic        pm_ignored;
  logic [15:0] svc_tab [SvcSlots];
  logic        svc_used[SvcSlots];
  logic [12:0] pmt_tab [PmtSlots];
  logic        pmt_used[PmtSlots];

  pat_section_program_table_top u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always #5 clk_i = ~clk_i;

  // cycle watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("tb_pat_section_program_table_top: errors");
      $finish;
    end
  end

  task automatic report(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    err_count++;
  endtask

  task automatic clear_tables();
    pm_pos = '0; pm_len = '0; pm_tsid = '0; pm_left = '0; pm_shift = '0;
    pm_ignored = 1'b1;
    for (int k = 0; k < SvcSlots; k++) svc_used[k] = 1'b0;
    for (int k = 0; k < PmtSlots; k++) pmt_used[k] = 1'b0;
  endtask

  // 0 known, 1 added, 2 full
  function automatic int svc_insert(input logic [15:0] svc);
    int spare;
    spare = -1;
    for (int k = 0; k < SvcSlots; k++) begin
      if (svc_used[k]) begin
        if (svc_tab[k] == svc) return 0;
      end else if (spare < 0) begin
        spare = k;
      end
    end
    if (spare < 0) return 2;
    svc_tab[spare] = svc;
    svc_used[spare] = 1'b1;
    return 1;
  endfunction

  function automatic int pmt_insert(input logic [12:0] pid);
    int spare;
    spare = -1;
    for (int k = 0; k < PmtSlots; k++) begin
      if (pmt_used[k]) begin
        if (pmt_tab[k] == pid) return 0;
      end else if (spare < 0) begin
        spare = k;
      end
    end
    if (spare < 0) return 2;
    pmt_tab[spare] = pid;
    pmt_used[spare] = 1'b1;
    return 1;
  endfunction

  // advance the parser by one byte; returns 1 when a record is due
  function automatic bit parse_byte(input logic [7:0] b, input logic st,
                                    output pat_record_t rec);
    logic [15:0] svc;
    logic [12:0] pid;
    int sres, pres;
    rec = '0;
    if (st) begin
      pm_ignored = (b != 8'h00);
      pm_pos = 10'd1; pm_left = '0; pm_shift = '0;
      return 1'b0;
    end
    if (pm_ignored) return 1'b0;
    if (pm_pos < 10'd8) begin
      case (pm_pos)
        10'd1: pm_len = {b[3:0], 8'h00};
        10'd2: begin
          pm_len[7:0] = b;
          if (pm_len < 12'd9) pm_left = '0;
          else if ((pm_len - 12'd9) / 4 > 511) pm_left = EntryCountMax;
          else pm_left = 9'((pm_len - 12'd9) / 4);
        end
        10'd3: pm_tsid = {b, 8'h00};
        10'd4: pm_tsid[7:0] = b;
        default: ;
      endcase
      pm_pos = pm_pos + 10'd1;
      return 1'b0;
    end
    if (pm_left == 0) return 1'b0;
    if (pm_pos < 10'd11) begin
      pm_shift = {pm_shift[15:0], b};
      pm_pos = pm_pos + 10'd1;
      return 1'b0;
    end
    pm_pos = 10'd8;
    pm_left = pm_left - 9'd1;
    svc = pm_shift[23:8];
    pid = {pm_shift[4:0], b};
    pm_shift = '0;
    rec.service_number = svc;
    rec.map_pid = pid;
    rec.stream_id = pm_tsid;
    if (pid < PidLowLimit || pid == PidNullValue) begin
      pm_ignored = 1'b1;
      pm_left = '0;
      rec.flags.entry_invalid = 1'b1;
      return 1'b1;
    end
    if (!(pid > PidStoreLimit && svc != 16'h0000)) return 1'b0;
    sres = svc_insert(svc);
    pres = pmt_insert(pid);
    if (sres == 0 && pres == 0) return 1'b0;
    rec.flags.service_added = (sres == 1);
    rec.flags.map_pid_added = (pres == 1);
    rec.flags.store_full = (sres == 2 || pres == 2);
    return 1'b1;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // append one record to the expected list
  task automatic add_expected(input pat_record_t r);
    record_q = {record_q, r};
  endtask

  // drive one item and wait for it to be taken
  task automatic send_item(input logic [7:0] b, input logic st,
                           input bit typed, input pat_record_t typed_rec);
    int unsigned gap;
    pat_record_t rec;
    bit due;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= st;
    do @(posedge clk_i); while (!s_axis_tready);
    due = parse_byte(b, st, rec);
    if (typed) add_expected(typed_rec);
    else if (due) add_expected(rec);
    @(negedge clk_i);
  endtask

  task automatic send_byte(input logic [7:0] b, input logic st);
    send_item(b, st, 1'b0, '0);
  endtask

  // result side backpressure
  initial begin
    int unsigned hold;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold > 0) begin
        hold--;
      end else begin
        m_axis_tready <= ~m_axis_tready;
        if (m_axis_tready) hold = pick_gap();
        else hold = $urandom_range(0, 6);
      end
    end
  end

  // compare each record with the oldest one due
  always @(posedge clk_i) begin
    pat_record_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (record_q.size() == 0) begin
        report("record with none due");
      end else begin
        want = record_q.pop_front();
        if (m_axis_tdata[15:0] !== want.service_number)
          report($sformatf("service %h want %h", m_axis_tdata[15:0], want.service_number));
        if (m_axis_tdata[28:16] !== want.map_pid)
          report($sformatf("pid %h want %h", m_axis_tdata[28:16], want.map_pid));
        if (m_axis_tdata[44:29] !== want.stream_id)
          report($sformatf("tsid %h want %h", m_axis_tdata[44:29], want.stream_id));
        if (m_axis_tdata[47:45] !== 3'b000) report("fill bits set");
        if (m_axis_tuser !== want.flags)
          report($sformatf("flags %b want %b", m_axis_tuser, want.flags));
      end
    end
  end

  // stimulus
  initial begin
    dir_row_t rows[27];
    int unsigned sent;
    int unsigned n_ent;
    logic [11:0] len;
    logic [15:0] svc;
    logic [12:0] pid;
    bit paused;
    rows = '{
      '{8'h47, 1'b0, 1'b0, '0},
      '{8'h00, 1'b1, 1'b0, '0},
      '{8'hB0, 1'b0, 1'b0, '0}, '{8'h15, 1'b0, 1'b0, '0},
      '{8'h12, 1'b0, 1'b0, '0}, '{8'h34, 1'b0, 1'b0, '0},
      '{8'hC1, 1'b0, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, '0},
      '{8'h00, 1'b0, 1'b0, '0},
      // first entry is new to both tables
      '{8'h00, 1'b0, 1'b0, '0}, '{8'h01, 1'b0, 1'b0, '0},
      '{8'hE1, 1'b0, 1'b0, '0},
      '{8'h00, 1'b0, 1'b1, '{16'h0001, 13'h0100, 16'h1234, 4'b0011}},
      // network pid entry, valid but not stored
      '{8'h00, 1'b0, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, '0},
      '{8'hE0, 1'b0, 1'b0, '0}, '{8'h10, 1'b0, 1'b0, '0},
      // pid below range ends the section
      '{8'hFF, 1'b0, 1'b0, '0}, '{8'hFF, 1'b0, 1'b0, '0},
      '{8'hE0, 1'b0, 1'b0, '0},
      '{8'h0F, 1'b0, 1'b1, '{16'hFFFF, 13'h000F, 16'h1234, 4'b0100}},
      '{8'h55, 1'b0, 1'b0, '0},
      // foreign table id, then a short section
      '{8'h02, 1'b1, 1'b0, '0}, '{8'h80, 1'b0, 1'b0, '0},
      '{8'h00, 1'b1, 1'b0, '0}, '{8'hB0, 1'b0, 1'b0, '0},
      '{8'h0C, 1'b0, 1'b0, '0}
    };
    clear_tables();
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (rows[i]) send_item(rows[i].sbyte, rows[i].sstart, rows[i].typed, rows[i].rec);

    // random sections, mostly well formed
    sent = 0;
    paused = 1'b0;
    while (sent < RandItems) begin
      if (!paused && sent > RandItems / 2) begin
        s_axis_tvalid <= 1'b0;
        while (record_q.size() != 0) @(negedge clk_i);
        paused = 1'b1;
      end
      if ($urandom_range(0, 9) == 0) begin
        send_byte(8'($urandom), $urandom_range(0, 7) == 0);
        sent++;
        continue;
      end
      n_ent = $urandom_range(0, 6);
      len = 12'(9 + 4 * n_ent + $urandom_range(0, 3));
      if ($urandom_range(0, 9) == 0) len = 12'($urandom);
      send_byte(($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'h00, 1'b1);
      send_byte({4'($urandom), len[11:8]}, 1'b0);
      send_byte(len[7:0], 1'b0);
      send_byte(8'($urandom), 1'b0);
      send_byte(8'($urandom), 1'b0);
      repeat (3) send_byte(8'($urandom), 1'b0);
      sent += 8;
      if (len >= 12'd9 && (len - 12'd9) / 4 > n_ent) n_ent = (len - 12'd9) / 4;
      if (n_ent > 8) n_ent = $urandom_range(0, 8);
      for (int e = 0; e < n_ent; e++) begin
        case ($urandom_range(0, 3))
          0: svc = 16'($urandom);
          1: svc = 16'($urandom_range(0, 15));
          default: svc = 16'($urandom_range(0, 90));
        endcase
        case ($urandom_range(0, 9))
          0: pid = 13'($urandom_range(0, 16'h12));
          1: pid = PidNullValue;
          2: pid = 13'($urandom);
          default: pid = 13'($urandom_range(16'h13, 16'h60));
        endcase
        send_byte(svc[15:8], 1'b0);
        send_byte(svc[7:0], 1'b0);
        send_byte({3'($urandom), pid[12:8]}, 1'b0);
        send_byte(pid[7:0], 1'b0);
        sent += 4;
      end
      repeat ($urandom_range(0, 4)) begin
        send_byte(8'($urandom), 1'b0);
        sent++;
      end
    end
    s_axis_tvalid <= 1'b0;

    // drain
    while (record_q.size() != 0) @(negedge clk_i);
    repeat (DrainWait) @(negedge clk_i);
    if (err_count == 0 && record_q.size() == 0) begin
      $display("tb_pat_section_program_table_top: clean");
    end else begin
      $display("tb_pat_section_program_table_top: errors");
    end
    $finish;
  end

endmodule
